### rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_ctrl, uer_scale and ultrasonic_echo_ranger_top.
package uer_pkg;

  // Default parameter values
  localparam int COUNT_BITS_DEF   = 16;
  localparam int TICKS_PER_CM_DEF = 14;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRIGGER_TICKS   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_SECONDS = 2'd1;
  localparam logic [1:0] CFG_CLAMP_COUNT     = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  TRIGGER_TICKS_RST   = 8'd3;
  localparam logic [3:0]  TIMEOUT_SECONDS_RST = 4'd2;
  localparam logic [15:0] CLAMP_COUNT_RST     = 16'd3556;

  // Saturated distance reported on overflow
  localparam logic [7:0] DIST_MAX = 8'd255;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [3:0]  timeout_seconds;
    logic [15:0] clamp_count;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo;
    logic second_pulse;
  } in_word_t;

  typedef struct packed {
    logic       trigger;
    logic       busy_res;
    logic       done_res;
    logic       fault;
    logic [7:0] distance_cm;
  } out_word_t;

endpackage

### rtl/uer_scale.sv
// Converts an echo width count into centimetres: clamp, divide, saturate.
// Depends on uer_pkg; division is a multiply by a fixed-point reciprocal.
module uer_scale
  import uer_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int TICKS_PER_CM = TICKS_PER_CM_DEF
) (
  input  logic [COUNT_BITS-1:0] width_count,
  input  logic [15:0]           clamp_count,
  output logic [7:0]            distance
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  // Reciprocal exact for 16-bit dividends and divisors up to 255
  localparam int SHIFT = 24;
  localparam int RECIP_W = SHIFT + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SHIFT) + longint'(TICKS_PER_CM) - 64'd1) / longint'(TICKS_PER_CM);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int PROD_W = 16 + RECIP_W;
  localparam int QUOT_W = PROD_W - SHIFT;

  logic [CMP_W-1:0]  width_ext;
  logic [CMP_W-1:0]  clamp_ext;
  logic [15:0]       clamped;
  logic [PROD_W-1:0] product;
  logic [QUOT_W-1:0] quot;

  // Clamp the count to the configured limit
  always_comb begin
    width_ext = CMP_W'(width_count);
    clamp_ext = CMP_W'(clamp_count);
    if (width_ext > clamp_ext) begin
      clamped = clamp_count;
    end else begin
      clamped = width_ext[15:0];
    end
  end

  // Divide by ticks per centimetre and saturate to eight bits
  assign product = PROD_W'(clamped) * PROD_W'(RECIP);
  assign quot    = product[PROD_W-1:SHIFT];

  always_comb begin
    if (quot > QUOT_W'(DIST_MAX)) begin
      distance = DIST_MAX;
    end else begin
      distance = quot[7:0];
    end
  end

endmodule

### rtl/uer_ctrl.sv
// Measurement sequencer: trigger, wait for echo with timeout, width count.
// Depends on uer_pkg and uer_scale.
module uer_ctrl
  import uer_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int TICKS_PER_CM = TICKS_PER_CM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  output out_word_t res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  logic [1:0]            phase_r, phase_nxt;
  logic [7:0]            trigger_count_r, trigger_count_nxt;
  logic [3:0]            second_count_r, second_count_nxt;
  logic [COUNT_BITS-1:0] width_count_r, width_count_nxt;
  logic [7:0]            last_distance_r, last_distance_nxt;
  logic                  done;
  logic                  flt;
  logic [7:0]            scaled;

  uer_scale #(
    .COUNT_BITS   (COUNT_BITS),
    .TICKS_PER_CM (TICKS_PER_CM)
  ) u_scale (
    .width_count (width_count_r),
    .clamp_count (cfg.clamp_count),
    .distance    (scaled)
  );

  // Next-state logic for one tick
  always_comb begin
    phase_nxt         = phase_r;
    trigger_count_nxt = trigger_count_r;
    second_count_nxt  = second_count_r;
    width_count_nxt   = width_count_r;
    last_distance_nxt = last_distance_r;
    done              = 1'b0;
    flt               = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_word.start_req) begin
          phase_nxt         = PH_TRIG;
          trigger_count_nxt = 8'd1;
        end
      end
      PH_TRIG: begin
        if (trigger_count_r >= cfg.trigger_ticks) begin
          phase_nxt        = PH_WAIT;
          second_count_nxt = '0;
        end else begin
          trigger_count_nxt = trigger_count_r + 8'd1;
        end
      end
      PH_WAIT: begin
        if (in_word.second_pulse) begin
          second_count_nxt = second_count_r + 4'd1;
        end
        // Timeout wins over a rising echo on the same tick
        if (in_word.second_pulse && (second_count_nxt >= cfg.timeout_seconds)) begin
          phase_nxt         = PH_IDLE;
          last_distance_nxt = '0;
          done              = 1'b1;
          flt               = 1'b1;
        end else if (in_word.echo) begin
          phase_nxt       = PH_MEAS;
          width_count_nxt = COUNT_BITS'(1);
        end
      end
      PH_MEAS: begin
        if (in_word.echo) begin
          if (&width_count_r) begin
            phase_nxt         = PH_IDLE;
            last_distance_nxt = DIST_MAX;
            done              = 1'b1;
          end else begin
            width_count_nxt = width_count_r + COUNT_BITS'(1);
          end
        end else begin
          phase_nxt         = PH_IDLE;
          last_distance_nxt = scaled;
          done              = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result word reflects the state after this tick
  always_comb begin
    res.trigger     = (phase_nxt == PH_TRIG);
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.fault       = flt;
    res.distance_cm = last_distance_nxt;
  end

  // Advance state only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      trigger_count_r <= '0;
      second_count_r  <= '0;
      width_count_r   <= '0;
      last_distance_r <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      trigger_count_r <= trigger_count_nxt;
      second_count_r  <= second_count_nxt;
      width_count_r   <= width_count_nxt;
      last_distance_r <= last_distance_nxt;
    end
  end

  // A low echo while measuring always ends the measurement
  a_meas_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_MEAS) && !in_word.echo |=> (phase_r == PH_IDLE))
    else $error("measurement did not end on low echo");

  // A timeout leaves a zero distance behind
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.fault |=> (last_distance_r == '0) && (phase_r == PH_IDLE))
    else $error("fault did not clear distance");

  // No state change without an accepted word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(last_distance_r))
    else $error("state changed without a word");

endmodule

### rtl/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger: config registers, sequencer, output register.
// Depends on uer_pkg, uer_ctrl and uer_scale.
//
//   channel | handshake           | word
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_stall   | in_data: start_req, echo, second_pulse
//   out     | out_valid / out_stall | out_data: trigger, busy_res, done_res, fault,
//           |                     |   distance_cm
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word in gives one word out; a word is taken every cycle that in_stall is low.
// The echo-width divide is a single reciprocal multiply ahead of the output register.
// Reset (synchronous, rst_n low) returns to idle with distance 0 and default config.
// in_stall rises only while the output register holds a word the sink is stalling.
// Config writes are always ready and take effect on the next accepted word.
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int TICKS_PER_CM = TICKS_PER_CM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;
  out_word_t res;
  logic      take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks   <= TRIGGER_TICKS_RST;
      cfg_r.timeout_seconds <= TIMEOUT_SECONDS_RST;
      cfg_r.clamp_count     <= CLAMP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRIGGER_TICKS:   cfg_r.trigger_ticks   <= cfg_data[7:0];
        CFG_TIMEOUT_SECONDS: cfg_r.timeout_seconds <= cfg_data[3:0];
        CFG_CLAMP_COUNT:     cfg_r.clamp_count     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  uer_ctrl #(
    .COUNT_BITS   (COUNT_BITS),
    .TICKS_PER_CM (TICKS_PER_CM)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (take),
    .in_word (in_data),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Output register: load on accept, drop when taken
  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
